@@ rtl/bfs_pkg.sv @@
// Shared types, constants and helpers for the bit field stack.
// No dependencies; every other file of the block imports this package.
package bfs_pkg;

    localparam int CAPACITY_BITS_DEF = 4096;
    localparam int MAX_FIELD         = 32;
    localparam int WORD_BITS         = 32;
    localparam int WORD_OFF_BITS     = 5;
    localparam int FIELD_WIDTH_BITS  = 6;
    localparam int VALUE_BITS        = 32;
    localparam int COUNT_BITS_DEF    = $clog2(CAPACITY_BITS_DEF + 1);

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_code_t;

    typedef enum logic {
        S_IDLE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;     // take the item and launch the memory reads
        logic commit;   // update the count and load the result
        logic mem_wr;   // write the merged words back
    } dp_cmd_t;

    typedef struct packed {
        logic push_ok;
    } dp_status_t;

    function automatic logic [FIELD_WIDTH_BITS-1:0] sat_width(
        input logic [FIELD_WIDTH_BITS-1:0] w
    );
        return (w > FIELD_WIDTH_BITS'(MAX_FIELD)) ? FIELD_WIDTH_BITS'(MAX_FIELD) : w;
    endfunction

endpackage

@@ rtl/bfs_if.sv @@
// Valid/ready channel interfaces for requests and results of the bit field stack.
// Depends on bfs_pkg for field widths.
interface bfs_in_if import bfs_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [FIELD_WIDTH_BITS-1:0] field_width;
    logic [VALUE_BITS-1:0]       value;

    modport source (output valid, mode, field_width, value, input ready);
    modport sink   (input valid, mode, field_width, value, output ready);
endinterface

interface bfs_out_if import bfs_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] popped;
    logic [COUNT_BITS-1:0] bit_total;
    logic [1:0]            status;

    modport source (output valid, popped, bit_total, status, input ready);
    modport sink   (input valid, popped, bit_total, status, output ready);
endinterface

@@ rtl/bfs_ctrl.sv @@
// Controller of the bit field stack: sequences accept and commit, owns result valid.
// Depends on bfs_pkg for state and command types.
module bfs_ctrl import bfs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        // accept only when the result register is free by the next edge
        in_ready       = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
        dp_cmd.load    = (state_reg == S_IDLE) && in_valid && in_ready;
        dp_cmd.commit  = (state_reg == S_FINISH);
        dp_cmd.mem_wr  = dp_cmd.commit && dp_status.push_ok;
        out_valid      = out_valid_reg;
        if (dp_cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

@@ rtl/bfs_datapath.sv @@
// Datapath of the bit field stack: bit count, two word banks, merge and extract logic.
// Depends on bfs_pkg; driven by bfs_ctrl through dp_cmd_t.
module bfs_datapath import bfs_pkg::*; #(
    parameter int CAPACITY_BITS = CAPACITY_BITS_DEF,
    localparam int CW = $clog2(CAPACITY_BITS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_cmd_t                     dp_cmd,
    output dp_status_t                  dp_status,
    input  logic                        mode,
    input  logic [FIELD_WIDTH_BITS-1:0] field_width,
    input  logic [VALUE_BITS-1:0]       value,
    output logic [VALUE_BITS-1:0]       popped,
    output logic [CW-1:0]               bit_total,
    output logic [1:0]                  status
);

    localparam int NWORDS     = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int BANK_DEPTH = (NWORDS + 1) / 2;
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int WIW        = CW - WORD_OFF_BITS;

    // word w lives in bank w[0] at address w>>1; a field touches one word of each bank
    logic [WORD_BITS-1:0] bank_ev [BANK_DEPTH];
    logic [WORD_BITS-1:0] bank_od [BANK_DEPTH];

    logic [CW-1:0]               bit_count_reg;
    logic [CW-1:0]               bit_count_next;
    logic                        mode_reg;
    logic [FIELD_WIDTH_BITS-1:0] wsat_reg;
    logic [WORD_OFF_BITS-1:0]    off_reg;
    logic                        odd_lo_reg;
    logic [VALUE_BITS-1:0]       value_reg;
    logic [BAW-1:0]              ev_addr_reg;
    logic [BAW-1:0]              od_addr_reg;
    logic [WORD_BITS-1:0]        rd_ev_reg;
    logic [WORD_BITS-1:0]        rd_od_reg;
    logic [VALUE_BITS-1:0]       popped_reg;
    logic [VALUE_BITS-1:0]       popped_next;
    status_code_t                status_reg;
    status_code_t                status_next;

    // accept-side address generation
    logic [FIELD_WIDTH_BITS-1:0] wsat_in;
    logic [CW-1:0]               sp_in;
    logic [WIW:0]                lo_ext;
    logic [WIW:0]                lo_inc;
    logic [BAW-1:0]              ev_addr;
    logic [BAW-1:0]              od_addr;

    always_comb
    begin
        wsat_in = sat_width(field_width);
        sp_in   = (mode == MODE_POP) ? (bit_count_reg - CW'(wsat_in)) : bit_count_reg;
        lo_ext  = {1'b0, sp_in[CW-1:WORD_OFF_BITS]};
        lo_inc  = lo_ext + (WIW + 1)'(1);
        ev_addr = lo_inc[BAW:1];
        od_addr = lo_ext[BAW:1];
    end

    // commit-side merge and extract
    logic [WORD_BITS-1:0]   lo_word;
    logic [WORD_BITS-1:0]   hi_word;
    logic [2*WORD_BITS-1:0] pair;
    logic [WORD_BITS:0]     mask_ext;
    logic [WORD_BITS-1:0]   fmask;
    logic [2*WORD_BITS-1:0] ins_mask;
    logic [2*WORD_BITS-1:0] ins_data;
    logic [2*WORD_BITS-1:0] merged;
    logic [2*WORD_BITS-1:0] shifted;
    logic [WORD_BITS-1:0]   got;
    logic [CW:0]            sum;
    logic                   push_ok;
    logic                   pop_ok;
    logic                   span;
    logic                   wr_ev;
    logic                   wr_od;
    logic [WORD_BITS-1:0]   ev_data;
    logic [WORD_BITS-1:0]   od_data;

    always_comb
    begin
        lo_word  = odd_lo_reg ? rd_od_reg : rd_ev_reg;
        hi_word  = odd_lo_reg ? rd_ev_reg : rd_od_reg;
        pair     = {hi_word, lo_word};
        mask_ext = ((WORD_BITS + 1)'(1) << wsat_reg) - (WORD_BITS + 1)'(1);
        fmask    = mask_ext[WORD_BITS-1:0];
        ins_mask = {{WORD_BITS{1'b0}}, fmask} << off_reg;
        ins_data = {{WORD_BITS{1'b0}}, value_reg & fmask} << off_reg;
        merged   = (pair & ~ins_mask) | ins_data;
        shifted  = pair >> off_reg;
        got      = shifted[WORD_BITS-1:0] & fmask;

        sum      = {1'b0, bit_count_reg} + (CW + 1)'(wsat_reg);
        push_ok  = (mode_reg == MODE_PUSH) && (sum <= (CW + 1)'(CAPACITY_BITS));
        pop_ok   = (mode_reg == MODE_POP) && (CW'(wsat_reg) <= bit_count_reg);
        dp_status.push_ok = push_ok;

        // second word is touched only when the field crosses a word boundary
        span     = ({2'b00, off_reg} + {1'b0, wsat_reg}) > 7'(WORD_BITS);
        ev_data  = odd_lo_reg ? merged[2*WORD_BITS-1:WORD_BITS] : merged[WORD_BITS-1:0];
        od_data  = odd_lo_reg ? merged[WORD_BITS-1:0] : merged[2*WORD_BITS-1:WORD_BITS];

        bit_count_next = bit_count_reg;
        popped_next    = '0;
        status_next    = STATUS_OK;
        if (push_ok)
            bit_count_next = sum[CW-1:0];
        else if (pop_ok)
        begin
            bit_count_next = bit_count_reg - CW'(wsat_reg);
            popped_next    = got;
        end
        else if (mode_reg == MODE_PUSH)
            status_next = STATUS_OVERFLOW;
        else
            status_next = STATUS_UNDERFLOW;
    end

    assign wr_ev = dp_cmd.mem_wr && (!odd_lo_reg || span);
    assign wr_od = dp_cmd.mem_wr && (odd_lo_reg || span);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_count_reg <= '0;
        else if (dp_cmd.commit)
            bit_count_reg <= bit_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            mode_reg    <= mode;
            wsat_reg    <= wsat_in;
            off_reg     <= sp_in[WORD_OFF_BITS-1:0];
            odd_lo_reg  <= sp_in[WORD_OFF_BITS];
            value_reg   <= value;
            ev_addr_reg <= ev_addr;
            od_addr_reg <= od_addr;
        end
        if (dp_cmd.commit)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ev)
            bank_ev[ev_addr_reg] <= ev_data;
        if (dp_cmd.load)
            rd_ev_reg <= bank_ev[ev_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_od)
            bank_od[od_addr_reg] <= od_data;
        if (dp_cmd.load)
            rd_od_reg <= bank_od[od_addr];
    end

    // the count changes only at commit, when the result register loads
    assign popped    = popped_reg;
    assign bit_total = bit_count_reg;
    assign status    = status_reg;

endmodule

@@ rtl/bit_field_stack_unit.sv @@
// Top level of the bit field stack: joins controller and datapath to the channels.
// Depends on bfs_pkg, bfs_if, bfs_ctrl and bfs_datapath.
//
//   channel  direction  payload
//   cmd      sink       mode, field_width, value
//   rsp      source     popped, bit_total, status
//
// For each item, the accept edge launches reads of both word banks, and
// the next edge merges and writes back (push) or extracts (pop) and loads the result.
// Only one item is in flight; the next is taken once the result register is free.
// A stalled result holds; no new item is taken until it is transferred.
// Reset empties the stack at once; the banks need no clearing.
module bit_field_stack_unit import bfs_pkg::*; #(
    parameter int CAPACITY_BITS = CAPACITY_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bfs_in_if.sink      cmd,
    bfs_out_if.source   rsp
);

    localparam int CW = $clog2(CAPACITY_BITS + 1);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic [1:0] status_bits;

    bfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    bfs_datapath #(
        .CAPACITY_BITS (CAPACITY_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .dp_status   (dp_status),
        .mode        (cmd.mode),
        .field_width (cmd.field_width),
        .value       (cmd.value),
        .popped      (rsp.popped),
        .bit_total   (rsp.bit_total),
        .status      (status_bits)
    );

    assign rsp.status = status_bits;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |-> ##2 rsp.valid)
        else $error("result not presented two cycles after transfer");

    a_ready_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> (!rsp.valid || rsp.ready))
        else $error("request taken while result register is occupied");

    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.bit_total <= CW'(CAPACITY_BITS)))
        else $error("bit count beyond capacity");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != STATUS_OK)) |-> (rsp.popped == '0))
        else $error("refused item returned data");

endmodule
